// ===== hdl/lffc_pkg.sv =====
// Package: shared constants, codes and types of the last-field frequency counter.
package lffc_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int NAME_BYTES_DEF  = 64;
  localparam int CHUNK_BYTES_DEF = 256;

  localparam logic [7:0] COLON_CHAR   = 8'h3A;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_END  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [2:0] STAT_HIT      = 3'd0;
  localparam logic [2:0] STAT_NEW      = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_TOO_LONG = 3'd3;
  localparam logic [2:0] STAT_READ     = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SR_LEN,
    ST_SR_LENW,
    ST_CMP,
    ST_CNT_R,
    ST_CNT_W,
    ST_COPY,
    ST_RD_REQ,
    ST_RD_WAIT,
    ST_EMIT
  } state_t;

  // control for the field buffer chain
  typedef struct packed {
    logic       load;
    logic       rotate;
    logic [7:0] data;
  } chain_ctl_t;

endpackage

// ===== hdl/lffc_if.sv =====
// Interfaces: input item channel and result channel.
interface lffc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic [5:0] read_index;
  logic [5:0] read_position;

  modport source(output valid, action, data_byte, read_index, read_position, input ready);
  modport sink(input valid, action, data_byte, read_index, read_position, output ready);
endinterface

interface lffc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  entry_index;
  logic [31:0] entry_count;
  logic [7:0]  name_byte;
  logic [5:0]  name_length;
  logic [6:0]  entries_in_use;

  modport source(output valid, status, entry_index, entry_count, name_byte, name_length,
                 entries_in_use, input ready);
  modport sink(input valid, status, entry_index, entry_count, name_byte, name_length,
               entries_in_use, output ready);
endinterface

// ===== hdl/lffc_ram.sv =====
// Generic single-port RAM with registered read.
module lffc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/lffc_cell.sv =====
// One byte cell of the field buffer chain.
module lffc_cell (
  input  logic       clk,
  input  logic       load,
  input  logic [7:0] load_byte,
  input  logic       rotate,
  input  logic [7:0] from_next,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_byte;
    end else if (rotate) begin
      q <= from_next;
    end
  end

endmodule

// ===== hdl/lffc_chain.sv =====
// Field buffer: a ring of byte cells that rotates toward cell 0.
module lffc_chain #(
  parameter int NAME_BYTES = lffc_pkg::NAME_BYTES_DEF
) (
  input  logic                          clk,
  input  lffc_pkg::chain_ctl_t          ctl,
  input  logic [$clog2(NAME_BYTES)-1:0] load_pos,
  output logic [7:0]                    head
);

  logic [7:0] q [NAME_BYTES];

  for (genvar g = 0; g < NAME_BYTES; g++) begin : g_cell
    lffc_cell u_cell (
      .clk       (clk),
      .load      (ctl.load && (load_pos == ($clog2(NAME_BYTES))'(g))),
      .load_byte (ctl.data),
      .rotate    (ctl.rotate),
      .from_next (q[(g + 1) % NAME_BYTES]),
      .q         (q[g])
    );
  end

  assign head = q[0];

endmodule

// ===== hdl/last_field_frequency_counter.sv =====
// Top level: last-field frequency counter.
//
//   channel  dir  payload
//   items    in   action, data_byte, read_index, read_position
//   results  out  status, entry_index, entry_count, name_byte, name_length, entries_in_use
//
// A stream byte that does not end a line is taken in IDLE. A line end after a colon, while no
// error has halted the table, walks it: SR_LEN and SR_LENW per entry of other length, and CMP
// per entry of equal length (the field ring makes one full turn against name RAM); then CNT_R
// and CNT_W to count, COPY to add or SR_LEN to flag an error; a read runs RD_REQ, RD_WAIT.
// Sync reset clears control state; memories are not cleared.
// A waiting result does not block input; a second result waits in EMIT for the output register.
module last_field_frequency_counter #(
  parameter int MAX_ENTRIES = lffc_pkg::MAX_ENTRIES_DEF,
  parameter int NAME_BYTES  = lffc_pkg::NAME_BYTES_DEF,
  parameter int CHUNK_BYTES = lffc_pkg::CHUNK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lffc_in_if.sink     items,
  lffc_out_if.source  results
);

  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int USED_W  = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W   = $clog2(NAME_BYTES);
  localparam int LEN_W   = $clog2(NAME_BYTES + 1);
  localparam int CHUNK_W = $clog2(CHUNK_BYTES);
  localparam int NADDR_W = $clog2(MAX_ENTRIES * NAME_BYTES);

  lffc_pkg::state_t state, state_next;

  logic [USED_W-1:0]  used;
  logic [USED_W-1:0]  walk;
  logic [LEN_W-1:0]   flen;
  logic               colon;
  logic               zero;
  logic [CHUNK_W-1:0] chunk;
  logic               halted;
  logic [LEN_W-1:0]   search_len;
  logic [POS_W-1:0]   k;
  logic               match;
  logic [5:0]         rd_index;
  logic [5:0]         rd_pos;

  logic [2:0]  res_status;
  logic [5:0]  res_index;
  logic [31:0] res_count;
  logic [7:0]  res_byte;
  logic [5:0]  res_len;

  logic        out_valid;

  // memory ports
  logic              len_we, cnt_we, name_we;
  logic [IDX_W-1:0]  len_addr, cnt_addr, row;
  logic [POS_W-1:0]  col;
  logic [NADDR_W-1:0] name_addr;
  logic [POS_W-1:0]  len_rd;
  logic [31:0]       cnt_wdata, cnt_rd;
  logic [7:0]        name_rd;

  lffc_pkg::chain_ctl_t chain_ctl;
  logic [7:0]           head;

  // byte path
  logic              in_acc, emit_ok, is_byte, is_end, is_read;
  logic              take, line_end, go_line, go_search, last_k, match_now, byte_hit;
  logic [LEN_W-1:0]  flen_after;
  logic              colon_after;
  logic [CHUNK_W:0]  chunk_inc;
  logic [IDX_W-1:0]  walk_idx, used_idx, rd_idx;

  assign in_acc  = items.valid && items.ready;
  assign emit_ok = !out_valid || results.ready;
  assign is_byte = items.action == lffc_pkg::ACT_BYTE;
  assign is_end  = (items.action == lffc_pkg::ACT_END) && (chunk != '0);
  assign is_read = items.action == lffc_pkg::ACT_READ;

  assign chunk_inc = {1'b0, chunk} + 1'b1;
  assign take = !zero && (items.data_byte != lffc_pkg::NEWLINE_CHAR) &&
                (items.data_byte != 8'd0) && (items.data_byte != lffc_pkg::COLON_CHAR) &&
                (flen < LEN_W'(NAME_BYTES));
  assign line_end = (items.data_byte == lffc_pkg::NEWLINE_CHAR) ||
                    (chunk_inc >= (CHUNK_W + 1)'(CHUNK_BYTES - 1));

  always_comb begin
    flen_after  = flen;
    colon_after = colon;
    if (is_byte && !zero && items.data_byte == lffc_pkg::COLON_CHAR) begin
      flen_after  = '0;
      colon_after = 1'b1;
    end else if (is_byte && take) begin
      flen_after = flen + 1'b1;
    end
  end

  assign go_line   = in_acc && ((is_byte && line_end) || is_end);
  assign go_search = go_line && !halted && colon_after;

  assign walk_idx = walk[IDX_W-1:0];
  assign used_idx = used[IDX_W-1:0];
  assign rd_idx   = IDX_W'(rd_index);
  assign last_k   = k == POS_W'(NAME_BYTES - 1);
  assign byte_hit = (LEN_W'(k) >= search_len) || (name_rd == head);
  assign match_now = match && byte_hit;

  assign items.ready = state == lffc_pkg::ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lffc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    len_we     = 1'b0;
    cnt_we     = 1'b0;
    name_we    = 1'b0;
    cnt_wdata  = cnt_rd + 32'd1;
    row        = walk_idx;
    col        = '0;
    chain_ctl.load   = in_acc && is_byte && take;
    chain_ctl.rotate = 1'b0;
    chain_ctl.data   = items.data_byte;
    unique case (state)
      lffc_pkg::ST_IDLE: begin
        if (go_search) begin
          state_next = lffc_pkg::ST_SR_LEN;
        end else if (in_acc && is_read) begin
          state_next = lffc_pkg::ST_RD_REQ;
        end
      end
      lffc_pkg::ST_SR_LEN: begin
        if (walk == used) begin
          if (used >= USED_W'(MAX_ENTRIES) || search_len >= LEN_W'(NAME_BYTES)) begin
            state_next = lffc_pkg::ST_EMIT;
          end else begin
            state_next = lffc_pkg::ST_COPY;
          end
        end else begin
          state_next = lffc_pkg::ST_SR_LENW;
        end
      end
      lffc_pkg::ST_SR_LENW: begin
        col = '0;
        if (LEN_W'(len_rd) == search_len) begin
          state_next = lffc_pkg::ST_CMP;
        end else begin
          state_next = lffc_pkg::ST_SR_LEN;
        end
      end
      lffc_pkg::ST_CMP: begin
        chain_ctl.rotate = 1'b1;
        col = k + 1'b1;
        if (last_k) begin
          state_next = match_now ? lffc_pkg::ST_CNT_R : lffc_pkg::ST_SR_LEN;
        end
      end
      lffc_pkg::ST_CNT_R: begin
        state_next = lffc_pkg::ST_CNT_W;
      end
      lffc_pkg::ST_CNT_W: begin
        cnt_we     = 1'b1;
        state_next = lffc_pkg::ST_EMIT;
      end
      lffc_pkg::ST_COPY: begin
        chain_ctl.rotate = 1'b1;
        row     = used_idx;
        col     = k;
        name_we = LEN_W'(k) < search_len;
        if (last_k) begin
          len_we     = 1'b1;
          cnt_we     = 1'b1;
          cnt_wdata  = 32'd1;
          state_next = lffc_pkg::ST_EMIT;
        end
      end
      lffc_pkg::ST_RD_REQ: begin
        row        = rd_idx;
        col        = POS_W'(rd_pos);
        state_next = lffc_pkg::ST_RD_WAIT;
      end
      lffc_pkg::ST_RD_WAIT: begin
        state_next = lffc_pkg::ST_EMIT;
      end
      lffc_pkg::ST_EMIT: begin
        if (emit_ok) begin
          state_next = lffc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lffc_pkg::ST_IDLE;
      end
    endcase
    len_addr = (state == lffc_pkg::ST_COPY) ? used_idx :
               (state == lffc_pkg::ST_RD_REQ) ? rd_idx : walk_idx;
    cnt_addr = len_addr;
  end

  assign name_addr = NADDR_W'(NADDR_W'(row) * NADDR_W'(NAME_BYTES)) + NADDR_W'(col);

  lffc_ram #(.WIDTH(POS_W), .DEPTH(MAX_ENTRIES)) u_len_ram (
    .clk(clk), .we(len_we), .addr(len_addr), .wdata(POS_W'(search_len)), .rdata(len_rd)
  );

  lffc_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rd)
  );

  lffc_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES * NAME_BYTES)) u_name_ram (
    .clk(clk), .we(name_we), .addr(name_addr), .wdata(head), .rdata(name_rd)
  );

  lffc_chain #(.NAME_BYTES(NAME_BYTES)) u_chain (
    .clk(clk), .ctl(chain_ctl), .load_pos(flen[POS_W-1:0]), .head(head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      flen      <= '0;
      colon     <= 1'b0;
      zero      <= 1'b0;
      chunk     <= '0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == lffc_pkg::ST_EMIT && emit_ok) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        lffc_pkg::ST_IDLE: begin
          if (in_acc && is_byte) begin
            if (line_end) begin
              flen  <= '0;
              colon <= 1'b0;
              zero  <= 1'b0;
              chunk <= '0;
            end else begin
              flen  <= flen_after;
              colon <= colon_after;
              chunk <= chunk_inc[CHUNK_W-1:0];
              if (items.data_byte == 8'd0) begin
                zero <= 1'b1;
              end
            end
            search_len <= flen_after;
            walk       <= '0;
          end else if (in_acc && is_end) begin
            search_len <= flen;
            walk       <= '0;
            flen       <= '0;
            colon      <= 1'b0;
            zero       <= 1'b0;
            chunk      <= '0;
          end else if (in_acc && is_read) begin
            rd_index <= items.read_index;
            rd_pos   <= items.read_position;
          end
        end
        lffc_pkg::ST_SR_LEN: begin
          k          <= '0;
          res_index  <= '0;
          res_count  <= '0;
          res_byte   <= '0;
          res_len    <= '0;
          if (walk == used) begin
            if (used >= USED_W'(MAX_ENTRIES)) begin
              res_status <= lffc_pkg::STAT_FULL;
              halted     <= 1'b1;
            end else if (search_len >= LEN_W'(NAME_BYTES)) begin
              res_status <= lffc_pkg::STAT_TOO_LONG;
              halted     <= 1'b1;
            end
          end
        end
        lffc_pkg::ST_SR_LENW: begin
          k     <= '0;
          match <= 1'b1;
          if (LEN_W'(len_rd) != search_len) begin
            walk <= walk + 1'b1;
          end
        end
        lffc_pkg::ST_CMP: begin
          k     <= k + 1'b1;
          match <= match_now;
          if (last_k && !match_now) begin
            walk <= walk + 1'b1;
          end
        end
        lffc_pkg::ST_CNT_R: begin
        end
        lffc_pkg::ST_CNT_W: begin
          res_status <= lffc_pkg::STAT_HIT;
          res_index  <= 6'(walk);
          res_count  <= cnt_rd + 32'd1;
          res_byte   <= '0;
          res_len    <= 6'(search_len);
        end
        lffc_pkg::ST_COPY: begin
          k <= k + 1'b1;
          if (last_k) begin
            used       <= used + 1'b1;
            res_status <= lffc_pkg::STAT_NEW;
            res_index  <= 6'(used);
            res_count  <= 32'd1;
            res_byte   <= '0;
            res_len    <= 6'(search_len);
          end
        end
        lffc_pkg::ST_RD_REQ: begin
        end
        lffc_pkg::ST_RD_WAIT: begin
          res_status <= lffc_pkg::STAT_READ;
          res_index  <= rd_index;
          if ({3'd0, rd_index} >= 9'(used) || {3'd0, rd_index} >= 9'(MAX_ENTRIES)) begin
            res_count <= '0;
            res_byte  <= '0;
            res_len   <= '0;
          end else begin
            res_count <= cnt_rd;
            res_len   <= 6'(len_rd);
            if ({3'd0, rd_pos} < 9'(len_rd) && {3'd0, rd_pos} < 9'(NAME_BYTES)) begin
              res_byte <= name_rd;
            end else begin
              res_byte <= '0;
            end
          end
        end
        lffc_pkg::ST_EMIT: begin
          if (emit_ok) begin
            results.status         <= res_status;
            results.entry_index    <= res_index;
            results.entry_count    <= res_count;
            results.name_byte      <= res_byte;
            results.name_length    <= res_len;
            results.entries_in_use <= 7'(used);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign results.valid = out_valid;

  a_cmp_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == lffc_pkg::ST_CMP) |-> (walk < used))
    else $error("compare on entry beyond table");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(MAX_ENTRIES))
    else $error("table count above capacity");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == lffc_pkg::ST_EMIT && emit_ok) |=> results.valid)
    else $error("result lost at emit");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (rst)
    (state == lffc_pkg::ST_EMIT && emit_ok) |=> items.ready)
    else $error("input not reopened after result");

endmodule

// ===== tb/last_field_frequency_counter_test.sv =====
// Testbench: self-checking random and directed test of the last-field frequency counter.
module last_field_frequency_counter_test;

  localparam int TABLE_SIZE = lffc_pkg::MAX_ENTRIES_DEF;
  localparam int NAME_MAX   = lffc_pkg::NAME_BYTES_DEF;
  localparam int LINE_CUT   = lffc_pkg::CHUNK_BYTES_DEF - 1;
  localparam int POOL_SIZE  = 40;
  localparam int RANDOM_BUDGET = 380;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  status;
    logic [5:0]  entry_index;
    logic [31:0] entry_count;
    logic [7:0]  name_byte;
    logic [5:0]  name_length;
    logic [6:0]  entries_in_use;
  } tally_result_t;

  logic clk;
  logic rst;

  lffc_in_if  items();
  lffc_out_if results();

  last_field_frequency_counter uut (
    .clk(clk),
    .rst(rst),
    .items(items),
    .results(results)
  );

  // predictor state
  logic [7:0]  tbl_name [TABLE_SIZE][NAME_MAX];
  int          tbl_len [TABLE_SIZE];
  logic [31:0] tbl_count [TABLE_SIZE];
  int          tbl_used;
  logic [7:0]  line_field [NAME_MAX];
  int          line_field_len;
  bit          line_colon;
  int          line_bytes;
  bit          line_zero;
  bit          table_halted;

  tally_result_t pending_results[$];

  int errors;
  int status_seen [8];
  int items_sent;
  int burst_left;
  int gap_max;
  int hold_left;
  int ready_pct;
  int ready_phase;

  logic [7:0] pool_name [POOL_SIZE][NAME_MAX];
  int         pool_len [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("last_field_frequency_counter_test NOT OK");
    $finish;
  end

  // receiver: long hold-off when requested, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      results.ready <= 1'b0;
    end else begin
      ready_phase = ready_phase + 1;
      if (ready_phase % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            ready_pct = 100;
          end
          1: begin
            ready_pct = 70;
          end
          2: begin
            ready_pct = 30;
          end
          default: begin
            ready_pct = 90;
          end
        endcase
      end
      results.ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    begin
      errors++;
      if (errors <= 40)
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    tally_result_t want;
    if (!rst && results.valid && results.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction, status", results.status, -1);
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (results.status !== want.status)
          report_mismatch("status", results.status, want.status);
        if (results.entry_index !== want.entry_index)
          report_mismatch("entry_index", results.entry_index, want.entry_index);
        if (results.entry_count !== want.entry_count)
          report_mismatch("entry_count", results.entry_count, want.entry_count);
        if (results.name_byte !== want.name_byte)
          report_mismatch("name_byte", results.name_byte, want.name_byte);
        if (results.name_length !== want.name_length)
          report_mismatch("name_length", results.name_length, want.name_length);
        if (results.entries_in_use !== want.entries_in_use)
          report_mismatch("entries_in_use", results.entries_in_use, want.entries_in_use);
      end
    end
  end

  task automatic push_result(input logic [2:0] st, input int idx, input logic [31:0] cnt,
                             input logic [7:0] nb, input int len);
    tally_result_t r;
    begin
      r.status = st;
      r.entry_index = idx[5:0];
      r.entry_count = cnt;
      r.name_byte = nb;
      r.name_length = len[5:0];
      r.entries_in_use = tbl_used[6:0];
      pending_results.push_back(r);
    end
  endtask

  task automatic close_line();
    bit had_colon;
    int len;
    bit same;
    begin
      had_colon = line_colon;
      len = line_field_len;
      line_field_len = 0;
      line_colon = 0;
      line_bytes = 0;
      line_zero = 0;
      if (!table_halted && had_colon) begin
        for (int i = 0; i < tbl_used; i++) begin
          if (tbl_len[i] == len) begin
            same = 1;
            for (int k = 0; k < len; k++)
              if (tbl_name[i][k] != line_field[k]) same = 0;
            if (same) begin
              tbl_count[i] = tbl_count[i] + 32'd1;
              push_result(lffc_pkg::STAT_HIT, i, tbl_count[i], 8'd0, len);
              return;
            end
          end
        end
        if (tbl_used >= TABLE_SIZE) begin
          table_halted = 1;
          push_result(lffc_pkg::STAT_FULL, 0, 32'd0, 8'd0, 0);
        end else if (len >= NAME_MAX) begin
          table_halted = 1;
          push_result(lffc_pkg::STAT_TOO_LONG, 0, 32'd0, 8'd0, 0);
        end else begin
          for (int k = 0; k < len; k++) tbl_name[tbl_used][k] = line_field[k];
          tbl_len[tbl_used] = len;
          tbl_count[tbl_used] = 32'd1;
          tbl_used++;
          push_result(lffc_pkg::STAT_NEW, tbl_used - 1, 32'd1, 8'd0, len);
        end
      end
    end
  endtask

  task automatic predict_tally(input logic [1:0] act, input logic [7:0] b,
                               input logic [5:0] idx, input logic [5:0] pos);
    logic [7:0] nb;
    begin
      case (act)
        lffc_pkg::ACT_BYTE: begin
          line_bytes++;
          if (!line_zero && b != lffc_pkg::NEWLINE_CHAR) begin
            if (b == 8'd0) begin
              line_zero = 1;
            end else if (b == lffc_pkg::COLON_CHAR) begin
              line_colon = 1;
              line_field_len = 0;
            end else if (line_field_len < NAME_MAX) begin
              line_field[line_field_len] = b;
              line_field_len++;
            end
          end
          if (b == lffc_pkg::NEWLINE_CHAR || line_bytes >= LINE_CUT) close_line();
        end
        lffc_pkg::ACT_END: begin
          if (line_bytes != 0) close_line();
        end
        lffc_pkg::ACT_READ: begin
          if (idx >= tbl_used) begin
            push_result(lffc_pkg::STAT_READ, idx, 32'd0, 8'd0, 0);
          end else begin
            nb = (pos < tbl_len[idx]) ? tbl_name[idx][pos] : 8'd0;
            push_result(lffc_pkg::STAT_READ, idx, tbl_count[idx], nb, tbl_len[idx]);
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  // one transaction on the item channel, with bursts and gaps
  task automatic send_item(input logic [1:0] act, input logic [7:0] b,
                           input logic [5:0] idx, input logic [5:0] pos);
    int gap;
    begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) begin
          items.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      items.valid <= 1'b1;
      items.action <= act;
      items.data_byte <= b;
      items.read_index <= idx;
      items.read_position <= pos;
      predict_tally(act, b, idx, pos);
      items_sent++;
      do @(posedge clk); while (!items.ready);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(lffc_pkg::ACT_BYTE, b, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_read(input logic [5:0] idx, input logic [5:0] pos);
    send_item(lffc_pkg::ACT_READ, 8'($urandom_range(0, 255)), idx, pos);
  endtask

  task automatic send_end();
    send_item(lffc_pkg::ACT_END, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
              6'($urandom_range(0, 63)));
  endtask

  task automatic wait_drained();
    begin
      items.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    begin
      c = 8'($urandom_range(1, 255));
      if (c == lffc_pkg::COLON_CHAR || c == lffc_pkg::NEWLINE_CHAR) c = 8'h41;
      return c;
    end
  endfunction

  task automatic send_pool_line(input int p, input bit end_by_action);
    begin
      if ($urandom_range(0, 2) == 0) begin
        send_text("x");
        send_byte(lffc_pkg::COLON_CHAR);
      end
      send_byte(lffc_pkg::COLON_CHAR);
      for (int k = 0; k < pool_len[p]; k++) send_byte(pool_name[p][k]);
      if ($urandom_range(0, 7) == 0) begin
        send_byte(8'd0);
        send_text("j:k");
      end
      if (end_by_action) send_end();
      else send_byte(lffc_pkg::NEWLINE_CHAR);
    end
  endtask

  task automatic test_directed();
    begin
      send_text("ab:c\n");
      send_text("q:c\n");
      send_text("a:b:dd\n");
      send_read(6'd0, 6'd0);
      send_read(6'd1, 6'd1);
      send_read(6'd1, 6'd63);
      send_read(6'd63, 6'd0);
      send_text("none\n");
      send_text("p:q");
      send_byte(8'd0);
      send_text(":zz\n");
      send_item(ACT_UNUSED, 8'hFF, 6'h3F, 6'h3F);
      send_end();
      send_text("k:");
      send_end();
      send_byte(8'hFF);
      send_byte(lffc_pkg::COLON_CHAR);
      send_byte(8'h80);
      send_byte(lffc_pkg::NEWLINE_CHAR);
      send_read(6'd4, 6'd0);
      send_read(6'd3, 6'd0);
      wait_drained();
    end
  endtask

  task automatic test_random_traffic();
    int sel;
    bit held;
    bit drained;
    logic [7:0] c;
    begin
      for (int p = 0; p < POOL_SIZE; p++) begin
        pool_len[p] = (p < 4) ? $urandom_range(20, 63) : $urandom_range(1, 8);
        for (int k = 0; k < NAME_MAX; k++) pool_name[p][k] = name_char();
      end
      held = 0;
      drained = 0;
      while (items_sent < RANDOM_BUDGET) begin
        sel = $urandom_range(0, 99);
        if (!held) gap_max = (items_sent >= 110 && items_sent < 160) ? 0 : 6;
        if (!held && items_sent >= 200) begin
          // long receiver hold-off while the sender keeps offering
          hold_left = 400;
          gap_max = 0;
          held = 1;
        end
        if (!drained && items_sent >= 280) begin
          wait_drained();
          gap_max = 6;
          drained = 1;
        end
        if (sel < 60) begin
          send_pool_line($urandom_range(0, POOL_SIZE - 1), $urandom_range(0, 9) == 0);
        end else if (sel < 80) begin
          send_read(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        end else if (sel < 95) begin
          for (int k = $urandom_range(1, 12); k > 0; k--) begin
            c = 8'($urandom_range(0, 255));
            if (c == lffc_pkg::COLON_CHAR) c = 8'h3B;
            send_byte(c);
          end
          send_byte(lffc_pkg::NEWLINE_CHAR);
        end else begin
          send_item(ACT_UNUSED, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                    6'($urandom_range(0, 63)));
          send_end();
        end
      end
      for (int i = 0; i < TABLE_SIZE; i++) send_read(6'(i), 6'($urandom_range(0, 7)));
      wait_drained();
    end
  endtask

  // only one error can be raised per run, so the seed picks which one
  task automatic test_sticky_error();
    int k;
    begin
      if ($urandom_range(0, 1) == 0) begin
        send_text("z:");
        for (int i = 0; i < LINE_CUT - 2; i++) send_byte(8'h79);
      end else begin
        k = 0;
        while (tbl_used < TABLE_SIZE) begin
          send_byte(lffc_pkg::COLON_CHAR);
          send_byte(8'h7E);
          send_byte(k[7:0] + 8'd1);
          send_byte(lffc_pkg::NEWLINE_CHAR);
          k++;
        end
        send_byte(lffc_pkg::COLON_CHAR);
        for (int i = 0; i < NAME_MAX + 2; i++) send_byte(8'h7F);
        send_byte(lffc_pkg::NEWLINE_CHAR);
      end
      send_text("after:err\n");
      send_text("tail:x");
      send_end();
      send_read(6'd0, 6'd0);
      send_read(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      wait_drained();
    end
  endtask

  initial begin
    rst = 1'b1;
    items.valid = 1'b0;
    items.action = lffc_pkg::ACT_BYTE;
    items.data_byte = 8'd0;
    items.read_index = 6'd0;
    items.read_position = 6'd0;
    results.ready = 1'b0;
    errors = 0;
    items_sent = 0;
    burst_left = 0;
    gap_max = 6;
    hold_left = 0;
    ready_pct = 80;
    ready_phase = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    tbl_used = 0;
    line_field_len = 0;
    line_colon = 0;
    line_bytes = 0;
    line_zero = 0;
    table_halted = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic();
    test_sticky_error();

    items.valid <= 1'b0;
    repeat (5000) @(posedge clk);
    $display("sent %0d items; results: %0d hit, %0d new, %0d full, %0d too long, %0d reads",
             items_sent, status_seen[lffc_pkg::STAT_HIT], status_seen[lffc_pkg::STAT_NEW],
             status_seen[lffc_pkg::STAT_FULL], status_seen[lffc_pkg::STAT_TOO_LONG],
             status_seen[lffc_pkg::STAT_READ]);
    $display("table held %0d names; %0d left pending, %0d mismatches",
             tbl_used, pending_results.size(), errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("last_field_frequency_counter_test OK");
    end else begin
      $display("last_field_frequency_counter_test NOT OK");
    end
    $finish;
  end

endmodule
